[rtl/r5ac_pkg.sv]
package r5ac_pkg;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [24:0]        logical_sector;
        logic [3:0]         disk_index;
        logic signed [31:0] record_value;
        logic               last_item;
        logic               first_item;
        logic [5:0]         word_index;
        logic [63:0]        word_a;
        logic [63:0]        word_b;
        logic [63:0]        word_c;
    } t_in;

    typedef struct packed {
        logic [1:0]         array_status;
        logic [15:0]        good_mask;
        logic signed [31:0] generation;
        logic [3:0]         target_disk;
        logic [20:0]        row;
        logic [3:0]         parity_disk;
        logic [1:0]         access_mode;
        logic               write_parity;
        logic               write_data;
        logic [4:0]         problem_disk;
        logic [24:0]        capacity;
        logic [63:0]        word_out;
    } t_out;

    localparam logic [2:0] OP_RECORD = 3'd0;
    localparam logic [2:0] OP_STOP   = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_ERROR  = 3'd4;
    localparam logic [2:0] OP_RESYNC = 3'd5;
    localparam logic [2:0] OP_XACC   = 3'd6;
    localparam logic [2:0] OP_PARITY = 3'd7;

    localparam logic [1:0] ST_STOPPED  = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_DEGRADED = 2'd2;
    localparam logic [1:0] ST_FAILED   = 2'd3;

    localparam logic [1:0] AM_DIRECT  = 2'd0;
    localparam logic [1:0] AM_RECON   = 2'd1;
    localparam logic [1:0] AM_REFUSED = 2'd2;

    localparam logic [0:0] CFG_DISKS   = 1'd0;
    localparam logic [0:0] CFG_SECTORS = 1'd1;

    // divider request / answer
    typedef struct packed {
        logic        start;
        logic [24:0] dividend;
        logic [4:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [24:0] quot;
        logic [4:0]  rem;
    } t_div_rsp;

endpackage

[rtl/r5ac_div.sv]
module r5ac_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  r5ac_pkg::t_div_req i_req,
    output r5ac_pkg::t_div_rsp o_rsp
);
    import r5ac_pkg::*;

    logic [24:0] r_q, n_q;
    logic [5:0]  r_rem, n_rem;
    logic [4:0]  r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [5:0]  shifted;

    // restoring division, one quotient bit per cycle
    always_comb begin
        shifted = {r_rem[4:0], r_q[24]};
        n_q     = {r_q[23:0], 1'b0};
        n_rem   = shifted;
        if (shifted >= {1'b0, r_den}) begin
            n_rem   = shifted - {1'b0, r_den};
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd24;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem[4:0];

endmodule

[rtl/raid5_array_controller.sv]
// Map runs two divisions in turn; vote counts, for each record, the records that match
// it, then makes a mask pass over the records.
// Throughput: one request at a time; a new one is taken in the cycle after the result
// enters the output register, where it waits out any output stall.
// Reset: synchronous active low; status stopped, all disks good, generation 1,
// disk count 3, 2048 sectors. Record and buffer memories hold no reset value.
module raid5_array_controller #(
    parameter int MAX_DISKS    = 16,
    parameter int SECTOR_WORDS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  r5ac_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output r5ac_pkg::t_out o_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [0:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import r5ac_pkg::*;

    localparam int WI_W = $clog2(SECTOR_WORDS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EXEC  = 10'b0000000010,
        S_XRD   = 10'b0000000100,
        S_DIV1  = 10'b0000001000,
        S_DIV2  = 10'b0000010000,
        S_VRDI  = 10'b0000100000,
        S_VRDJ  = 10'b0001000000,
        S_VMASK = 10'b0010000000,
        S_VEND  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    t_in    r_req;
    t_out   r_res;      // result under construction
    t_out   r_out;      // output register, holds while stalled
    t_out   n_out;
    logic   r_ovalid;

    logic [4:0]  r_disks_reg;
    logic [21:0] r_sect_reg;
    logic [15:0] r_good;
    logic [1:0]  r_status;
    logic [31:0] r_gen;

    // clamp configuration into range
    logic [4:0]  n_disks;
    logic [21:0] n_sect;
    always_comb begin
        n_disks = r_disks_reg;
        if (n_disks < 5'd3) n_disks = 5'd3;
        if (n_disks > 5'(MAX_DISKS)) n_disks = 5'(MAX_DISKS);
        if (n_disks > 5'd16) n_disks = 5'd16;
        n_sect = r_sect_reg;
        if (n_sect < 22'd2048) n_sect = 22'd2048;
        if (r_sect_reg > 22'd2097152 || r_sect_reg == 22'h3FFFFF) n_sect = 22'd2097152;
    end

    // lowest bad disk below the count
    logic [4:0] lowest;
    always_comb begin
        lowest = 5'd16;
        for (int i = 15; i >= 0; i--)
            if (5'(i) < n_disks && !r_good[i]) lowest = 5'(i);
    end

    // capacity product, registered off the config registers
    logic [24:0] r_cap;
    always_ff @(posedge i_clk) begin
        r_cap <= 25'({20'd0, n_disks - 5'd1} * {3'd0, n_sect - 22'd2});
    end

    // record memory, one read port
    logic [31:0] rec_mem [16];
    logic [31:0] r_rec_rd;
    logic [3:0]  rec_ra;
    logic        rec_we;

    // sector buffer memory
    logic [63:0] buf_mem [SECTOR_WORDS];
    logic [63:0] r_buf_rd;
    logic        buf_we;
    logic [63:0] buf_wd;
    logic [WI_W-1:0] buf_a;
    logic        wi_ok;
    assign buf_a = WI_W'(r_req.word_index);
    assign wi_ok = (32'(r_req.word_index) < 32'(SECTOR_WORDS));

    always_ff @(posedge i_clk) begin
        if (rec_we) rec_mem[r_req.disk_index] <= r_req.record_value;
        r_rec_rd <= rec_mem[rec_ra];
        if (buf_we) buf_mem[buf_a] <= buf_wd;
        r_buf_rd <= buf_mem[buf_a];
    end

    // divider
    t_div_req dreq;
    t_div_rsp drsp;
    r5ac_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(dreq), .o_rsp(drsp));

    // vote counters
    logic [3:0]  r_vi;
    logic [4:0]  r_vj;
    logic [31:0] r_cur, r_best;
    logic [4:0]  r_cnt, r_bcnt;
    logic [4:0]  r_bad;
    logic [15:0] r_mask;
    logic [24:0] r_quot;
    logic [4:0]  r_col;
    logic        cur_bad;

    // record under the mask pass is unreadable or disagrees with the winner
    assign cur_bad = (r_rec_rd == 32'hFFFFFFFF) || (r_rec_rd != r_best);

    logic [4:0] pdisk_w, tgt_w;
    assign pdisk_w = drsp.rem;
    assign tgt_w   = (r_col < pdisk_w) ? r_col : r_col + 5'd1;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;

    // array state fields join the result as it enters the output register
    always_comb begin
        n_out              = r_res;
        n_out.array_status = r_status;
        n_out.good_mask    = r_good;
        n_out.generation   = r_gen;
        n_out.problem_disk = lowest;
        n_out.capacity     = r_cap;
    end

    always_comb begin
        rec_we = (r_state == S_EXEC) && (r_req.opcode == OP_RECORD);
        buf_we = (r_state == S_XRD) && wi_ok;
        buf_wd = (r_req.first_item ? 64'd0 : r_buf_rd) ^ r_req.word_a;
        rec_ra = (r_state == S_VRDI || r_state == S_VMASK) ? r_vi : r_vj[3:0];
        dreq.start    = 1'b0;
        dreq.dividend = r_req.logical_sector;
        dreq.divisor  = n_disks - 5'd1;
        if (r_state == S_EXEC && (r_req.opcode == OP_READ || r_req.opcode == OP_WRITE))
            dreq.start = 1'b1;
        if (r_state == S_DIV1 && drsp.done) begin
            dreq.start    = 1'b1;
            dreq.dividend = drsp.quot;
            dreq.divisor  = n_disks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_good      <= 16'hFFFF;
            r_status    <= ST_STOPPED;
            r_gen       <= 32'd1;
            r_disks_reg <= 5'd3;
            r_sect_reg  <= 22'd2048;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_DISKS) r_disks_reg <= i_cfg_data[4:0];
                else r_sect_reg <= i_cfg_data[21:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_data;
                        r_res   <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_req.opcode)
                        OP_RECORD: begin
                            if (r_req.last_item) begin
                                r_vi <= '0; r_bcnt <= '0; r_best <= '0;
                                r_state <= S_VRDI;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        OP_STOP: begin
                            r_gen <= r_gen + 32'd1;
                            r_status <= ST_STOPPED;
                            r_state <= S_OUT;
                        end
                        OP_READ, OP_WRITE: r_state <= S_DIV1;
                        OP_ERROR: begin
                            if (r_status != ST_STOPPED && {1'b0, r_req.disk_index} < n_disks) begin
                                r_good[r_req.disk_index] <= 1'b0;
                                if (r_status == ST_OK) r_status <= ST_DEGRADED;
                                else r_status <= ST_FAILED;
                            end
                            r_state <= S_OUT;
                        end
                        OP_RESYNC: begin
                            if (r_status == ST_DEGRADED) begin
                                if (lowest != 5'd16) r_good[lowest[3:0]] <= 1'b1;
                                r_status <= ST_OK;
                            end
                            r_state <= S_OUT;
                        end
                        OP_XACC: r_state <= wi_ok ? S_XRD : S_OUT;
                        OP_PARITY: begin
                            r_res.word_out <= r_req.word_a ^ r_req.word_b ^ r_req.word_c;
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_XRD: begin
                    r_res.word_out <= buf_wd;
                    r_state <= S_OUT;
                end
                S_DIV1: begin
                    if (drsp.done) begin
                        r_quot  <= drsp.quot;
                        r_col   <= drsp.rem;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (drsp.done) begin
                        r_res.parity_disk <= pdisk_w[3:0];
                        r_res.target_disk <= tgt_w[3:0];
                        r_res.row         <= r_quot[20:0];
                        if (r_status == ST_STOPPED) r_res.access_mode <= AM_REFUSED;
                        else begin
                            r_res.access_mode <= (!r_good[tgt_w[3:0]] && r_status == ST_DEGRADED)
                                                 ? AM_RECON : AM_DIRECT;
                            if (r_req.opcode == OP_WRITE) begin
                                r_res.write_parity <= r_good[pdisk_w[3:0]];
                                r_res.write_data   <= r_good[tgt_w[3:0]];
                            end
                        end
                        r_state <= S_OUT;
                    end
                end
                // vote: read record i, then walk j over all records
                S_VRDI: begin
                    r_vj <= '0; r_cnt <= '0;
                    r_state <= S_VRDJ;
                end
                S_VRDJ: begin
                    if (r_vj == 5'd0) r_cur <= r_rec_rd;
                    r_vj <= r_vj + 5'd1;
                    if (r_vj != 5'd0) begin
                        if (r_rec_rd == r_cur) r_cnt <= r_cnt + 5'd1;
                    end
                    if (r_vj == n_disks) begin
                        if ((r_rec_rd == r_cur ? r_cnt + 5'd1 : r_cnt) > r_bcnt) begin
                            r_bcnt <= (r_rec_rd == r_cur) ? r_cnt + 5'd1 : r_cnt;
                            r_best <= r_cur;
                        end
                        if ({1'b0, r_vi} == n_disks - 5'd1) begin
                            r_vi <= '0; r_bad <= '0; r_mask <= 16'hFFFF;
                            r_state <= S_VMASK;
                        end else begin
                            r_vi <= r_vi + 4'd1;
                            r_state <= S_VRDI;
                        end
                    end
                end
                S_VMASK: begin
                    r_state <= S_VEND;
                end
                S_VEND: begin
                    if (cur_bad) begin
                        r_mask[r_vi] <= 1'b0;
                        r_bad <= r_bad + 5'd1;
                    end
                    if ({1'b0, r_vi} == n_disks - 5'd1) begin
                        r_state <= S_OUT;
                        r_gen   <= r_best;
                        r_good  <= r_mask & ~(cur_bad ? (16'd1 << r_vi) : 16'd0);
                        // status from the total count of bad disks, this one included
                        if (r_bad == 5'd0 && !cur_bad) r_status <= ST_OK;
                        else if (r_bad + 5'(cur_bad) == 5'd1) r_status <= ST_DEGRADED;
                        else r_status <= ST_FAILED;
                    end else begin
                        r_vi <= r_vi + 4'd1;
                        r_state <= S_VMASK;
                    end
                end
                S_OUT: begin
                    // wait for the output slot to empty
                    if (!r_ovalid || !i_stall) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT)) else $error("result outside output state");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> (r_state == S_IDLE)) else $error("config while busy");

endmodule
